FILE: rtl/core/qoipd_pkg.sv
// Shared types, codes and decode helpers for the QOI-variant pixel decoder.
package qoipd_pkg;

  localparam int unsigned INDEX_SLOTS = 64;
  localparam int unsigned INDEX_AW    = $clog2(INDEX_SLOTS);
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXELS = 4'b0010,
    PH_DRAIN  = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_END   = 1'b1;
  localparam logic       KIND_SPAN = 1'b0;
  localparam logic       KIND_STAT = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_ZERO_DIM  = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  localparam logic [3:0] HDR_MAGIC3 = 4'd3;
  localparam logic [3:0] HDR_WID_LO = 4'd4;
  localparam logic [3:0] HDR_WID_HI = 4'd5;
  localparam logic [3:0] HDR_HGT_LO = 4'd6;
  localparam logic [3:0] HDR_HGT_HI = 4'd7;
  localparam logic [3:0] HDR_LEN_0  = 4'd8;
  localparam logic [3:0] HDR_LEN_1  = 4'd9;
  localparam logic [3:0] HDR_LEN_2  = 4'd10;
  localparam logic [3:0] HDR_LEN_3  = 4'd11;

  localparam logic [31:0] COLOUR_RESET = 32'h0000_00FF;
  localparam logic [13:0] RUN16_BIAS   = 14'd33;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h66;
      2'd1:    m = 8'h69;
      2'd2:    m = 8'h6F;
      default: m = 8'h71;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] extra_bytes(input logic [7:0] lead);
    logic [2:0] e;
    e = 3'd0;
    if (lead[7:5] == 3'b011) begin
      e = 3'd1;
    end else if (lead[7:5] == 3'b110) begin
      e = 3'd1;
    end else if (lead[7:4] == 4'hE) begin
      e = 3'd2;
    end else if (lead[7:4] == 4'hF) begin
      e = {2'b00, lead[3]} + {2'b00, lead[2]} + {2'b00, lead[1]} + {2'b00, lead[0]};
    end
    return e;
  endfunction

  function automatic logic [7:0] sext2(input logic [1:0] v);
    return {{6{v[1]}}, v};
  endfunction

  function automatic logic [7:0] sext4(input logic [3:0] v);
    return {{4{v[3]}}, v};
  endfunction

  function automatic logic [7:0] sext5(input logic [4:0] v);
    return {{3{v[4]}}, v};
  endfunction

endpackage

FILE: rtl/core/qoi_variant_pixel_decoder_core.sv
// Top level of the QOI-variant pixel decoder: header parse, op decode and span output.
// Takes one stream byte per cycle, back to back, while output results are taken. An
// accepted byte lands in an input register while the 64-slot colour index is read at
// the byte's low six bits; when that byte is processed the op is decoded, the state
// updated and a span or status result put in the output register. A waiting result
// stalls input only when the input register is also full. The index is a 64-entry
// memory with one valid flop per slot, so a new header clears it at once and no
// clearing pass is needed after reset.
module qoi_variant_pixel_decoder_core
  import qoipd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]             s_axis_tuser,   // [0] command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [63:32] span_count,
  // [79:64] image_width, [95:80] image_height, [97:96] status, [103:98] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]             m_axis_tuser    // [0] kind
);

  phase_t        phase, phase_next;
  logic [3:0]    header_count, header_count_next;
  logic [15:0]   width_reg, width_reg_next;
  logic [15:0]   height_reg, height_reg_next;
  logic [31:0]   payload_left, payload_left_next;
  logic [31:0]   pixels_left, pixels_left_next;
  logic [31:0]   colour, colour_next;
  logic [7:0]    op_lead, op_lead_next;
  logic [15:0]   op_low, op_low_next;
  logic [2:0]    op_needed, op_needed_next;
  logic [1:0]    error_code, error_code_next;

  logic          in_valid;
  logic          in_cmd;
  logic [7:0]    in_byte;
  logic [31:0]   rd_entry;

  logic [31:0]   index_mem [INDEX_SLOTS];
  logic [INDEX_SLOTS-1:0] index_valid;

  logic          out_valid;
  logic          out_kind;
  logic [31:0]   out_colour;
  logic [31:0]   out_count;
  logic [15:0]   out_width;
  logic [15:0]   out_height;
  logic [1:0]    out_status;

  logic          proc_en;
  logic          s_fire;

  logic [31:0]   pl_dec;
  logic [2:0]    extra;
  logic [7:0]    ex_lead;
  logic [15:0]   ex_low;
  logic [31:0]   ex_col_in;
  logic [31:0]   ex_col;
  logic [31:0]   idx_entry;
  logic [13:0]   ex_n;
  logic [31:0]   ex_span;
  logic [31:0]   ex_pix_after;
  logic [INDEX_AW-1:0] ex_hash;
  logic [31:0]   area;

  logic          wr_en;
  logic          clear_idx;
  logic          res_valid;
  logic          res_kind;
  logic [31:0]   res_colour;
  logic [31:0]   res_count;
  logic [1:0]    res_status;

  assign proc_en       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_en;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {6'd0, out_status, out_height, out_width, out_count,
                          out_colour[7:0], out_colour[15:8], out_colour[23:16],
                          out_colour[31:24]};

  assign area      = {16'd0, width_reg} * {16'd0, height_reg};
  assign idx_entry = index_valid[in_byte[INDEX_AW-1:0]] ? rd_entry : 32'd0;

  always_comb begin
    pl_dec    = payload_left - 32'd1;
    extra     = extra_bytes(in_byte);
    ex_lead   = in_byte;
    ex_low    = 16'd0;
    ex_col_in = colour;
    if (op_needed != 3'd0) begin
      ex_lead = op_lead;
      ex_low  = {op_low[7:0], in_byte};
      if (op_lead[7:4] == 4'hF) begin
        ex_low = op_low;
        if (op_lead[3]) begin
          ex_col_in[31:24] = in_byte;
          ex_lead[3]       = 1'b0;
        end else if (op_lead[2]) begin
          ex_col_in[23:16] = in_byte;
          ex_lead[2]       = 1'b0;
        end else if (op_lead[1]) begin
          ex_col_in[15:8]  = in_byte;
          ex_lead[1]       = 1'b0;
        end else begin
          ex_col_in[7:0]   = in_byte;
          ex_lead[0]       = 1'b0;
        end
      end
    end
  end

  always_comb begin
    logic [7:0]  r, g, b, a;
    logic [19:0] m;
    r = ex_col_in[31:24];
    g = ex_col_in[23:16];
    b = ex_col_in[15:8];
    a = ex_col_in[7:0];
    m = {ex_lead[3:0], ex_low};
    ex_n = 14'd1;
    if (ex_lead[7:6] == 2'b00) begin
      {r, g, b, a} = idx_entry;
    end else if (ex_lead[7:5] == 3'b010) begin
      ex_n = {9'd0, ex_lead[4:0]} + 14'd1;
    end else if (ex_lead[7:5] == 3'b011) begin
      ex_n = {1'b0, ex_lead[4:0], ex_low[7:0]} + RUN16_BIAS;
    end else if (ex_lead[7:6] == 2'b10) begin
      r = r + sext2(ex_lead[5:4]);
      g = g + sext2(ex_lead[3:2]);
      b = b + sext2(ex_lead[1:0]);
    end else if (ex_lead[7:5] == 3'b110) begin
      r = r + sext5(ex_lead[4:0]);
      g = g + sext4(ex_low[7:4]);
      b = b + sext4(ex_low[3:0]);
    end else if (ex_lead[7:4] == 4'hE) begin
      r = r + sext5(m[19:15]);
      g = g + sext5(m[14:10]);
      b = b + sext5(m[9:5]);
      a = a + sext5(m[4:0]);
    end
    ex_col  = {r, g, b, a};
    ex_hash = INDEX_AW'(r ^ g ^ b ^ a);
    if (pl_dec == 32'd0) begin
      ex_span = pixels_left;
    end else if ({18'd0, ex_n} < pixels_left) begin
      ex_span = {18'd0, ex_n};
    end else begin
      ex_span = pixels_left;
    end
    ex_pix_after = pixels_left - ex_span;
  end

  always_comb begin
    logic do_exec;
    logic [1:0] fail_code;
    logic do_fail;
    do_exec   = 1'b0;
    do_fail   = 1'b0;
    fail_code = ST_OK;

    phase_next        = phase;
    header_count_next = header_count;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    payload_left_next = payload_left;
    pixels_left_next  = pixels_left;
    colour_next       = colour;
    op_lead_next      = op_lead;
    op_low_next       = op_low;
    op_needed_next    = op_needed;
    error_code_next   = error_code;
    wr_en             = 1'b0;
    clear_idx         = 1'b0;
    res_valid         = 1'b0;
    res_kind          = KIND_SPAN;
    res_colour        = colour;
    res_count         = 32'd0;
    res_status        = ST_OK;

    if (in_cmd == CMD_END) begin
      res_valid  = 1'b1;
      res_kind   = KIND_STAT;
      res_colour = 32'd0;
      if (error_code != ST_OK) begin
        res_status = error_code;
      end else if (phase == PH_HEADER || payload_left != 32'd0) begin
        res_status = ST_TRUNC;
      end
      phase_next        = PH_HEADER;
      header_count_next = 4'd0;
      width_reg_next    = 16'd0;
      height_reg_next   = 16'd0;
      payload_left_next = 32'd0;
      pixels_left_next  = 32'd0;
      colour_next       = COLOUR_RESET;
      op_lead_next      = 8'd0;
      op_low_next       = 16'd0;
      op_needed_next    = 3'd0;
      error_code_next   = ST_OK;
      clear_idx         = 1'b1;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          header_count_next = header_count + 4'd1;
          unique case (header_count)
            HDR_WID_LO: width_reg_next = {8'd0, in_byte};
            HDR_WID_HI: width_reg_next = {in_byte, width_reg[7:0]};
            HDR_HGT_LO: height_reg_next = {8'd0, in_byte};
            HDR_HGT_HI: begin
              height_reg_next = {in_byte, height_reg[7:0]};
              if (width_reg == 16'd0 || {in_byte, height_reg[7:0]} == 16'd0) begin
                do_fail   = 1'b1;
                fail_code = ST_ZERO_DIM;
              end
            end
            HDR_LEN_0: payload_left_next[7:0]   = in_byte;
            HDR_LEN_1: payload_left_next[15:8]  = in_byte;
            HDR_LEN_2: payload_left_next[23:16] = in_byte;
            HDR_LEN_3: begin
              payload_left_next[31:24] = in_byte;
              clear_idx      = 1'b1;
              colour_next    = COLOUR_RESET;
              op_lead_next   = 8'd0;
              op_low_next    = 16'd0;
              op_needed_next = 3'd0;
              if ({in_byte, payload_left[23:0]} == 32'd0) begin
                pixels_left_next = 32'd0;
                phase_next       = PH_DRAIN;
                res_valid        = 1'b1;
                res_colour       = COLOUR_RESET;
                res_count        = area;
              end else begin
                pixels_left_next = area;
                phase_next       = PH_PIXELS;
              end
            end
            default: begin
              if (header_count <= HDR_MAGIC3 &&
                  in_byte != magic_byte(header_count[1:0])) begin
                do_fail   = 1'b1;
                fail_code = ST_BAD_MAGIC;
              end
            end
          endcase
        end
        PH_PIXELS: begin
          payload_left_next = pl_dec;
          if (op_needed == 3'd0) begin
            if ({29'd0, extra} > pl_dec) begin
              do_fail      = 1'b1;
              fail_code    = ST_TRUNC;
              op_lead_next = in_byte;
              op_low_next  = 16'd0;
            end else if (extra != 3'd0) begin
              op_needed_next = extra;
              op_lead_next   = in_byte;
              op_low_next    = 16'd0;
            end else begin
              do_exec = 1'b1;
            end
          end else begin
            op_needed_next = op_needed - 3'd1;
            op_lead_next   = ex_lead;
            op_low_next    = ex_low;
            colour_next    = ex_col_in;
            if (op_needed == 3'd1) begin
              do_exec = 1'b1;
            end
          end
          if (do_exec) begin
            colour_next      = ex_col;
            wr_en            = 1'b1;
            op_lead_next     = 8'd0;
            op_low_next      = 16'd0;
            pixels_left_next = ex_pix_after;
            if (ex_pix_after == 32'd0 || pl_dec == 32'd0) begin
              phase_next = PH_DRAIN;
            end
            res_valid  = 1'b1;
            res_colour = ex_col;
            res_count  = ex_span;
          end
        end
        PH_DRAIN: begin
          if (payload_left != 32'd0) begin
            payload_left_next = pl_dec;
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
      if (do_fail) begin
        phase_next = PH_STOP;
        if (error_code == ST_OK) begin
          error_code_next = fail_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && wr_en) begin
      index_mem[ex_hash] <= ex_col;
    end
    if (s_fire) begin
      if (proc_en && wr_en && ex_hash == s_axis_tdata[INDEX_AW-1:0]) begin
        rd_entry <= ex_col;
      end else begin
        rd_entry <= index_mem[s_axis_tdata[INDEX_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_valid <= '0;
    end else if (proc_en && clear_idx) begin
      index_valid <= '0;
    end else if (proc_en && wr_en) begin
      index_valid[ex_hash] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (proc_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cmd  <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 4'd0;
      width_reg    <= 16'd0;
      height_reg   <= 16'd0;
      payload_left <= 32'd0;
      pixels_left  <= 32'd0;
      colour       <= COLOUR_RESET;
      op_lead      <= 8'd0;
      op_low       <= 16'd0;
      op_needed    <= 3'd0;
      error_code   <= ST_OK;
    end else if (proc_en) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      payload_left <= payload_left_next;
      pixels_left  <= pixels_left_next;
      colour       <= colour_next;
      op_lead      <= op_lead_next;
      op_low       <= op_low_next;
      op_needed    <= op_needed_next;
      error_code   <= error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_en && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && res_valid) begin
      out_kind   <= res_kind;
      out_colour <= res_colour;
      out_count  <= res_count;
      out_width  <= width_reg;
      out_height <= height_reg;
      out_status <= res_status;
    end
  end

endmodule
